### sv/fwna_pkg.sv
package fwna_pkg;

  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 8;
  localparam int CHAR_W     = 7;
  localparam int NIB_W      = 4;
  localparam int HEX_DIGITS = VALUE_W / NIB_W;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * NIB_W;
  localparam int POS_W      = 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [COUNT_W-1:0] HEX_SELECT = COUNT_W'(16);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(8'h41);
  localparam logic [NIB_W-1:0]   NIB_TEN    = NIB_W'(10);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } dabble_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < NIB_TEN) begin
      ch = ASCII_ZERO + CHAR_W'(nib);
    end else begin
      ch = ASCII_A + CHAR_W'(nib - NIB_TEN);
    end
    return ch;
  endfunction

endpackage

### sv/fwna_dabble.sv
module fwna_dabble
  import fwna_pkg::*;
(
  input  logic                                clk,
  input  dabble_ctrl_t                        ctrl,
  input  logic [VALUE_W-1:0]                  value,
  output logic [DEC_DIGITS-1:0][NIB_W-1:0]    bcd
);

  logic [VALUE_W-1:0]                 bin;
  logic [DEC_DIGITS-1:0][NIB_W-1:0]   adj;
  logic [BCD_W-1:0]                   adj_flat;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i] >= NIB_W'(5)) begin
        adj[i] = bcd[i] + NIB_W'(3);
      end else begin
        adj[i] = bcd[i];
      end
    end
  end

  assign adj_flat = adj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= value;
      bcd <= '0;
    end else if (ctrl.step) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {adj_flat[BCD_W-2:0], bin[VALUE_W-1]};
    end
  end

endmodule

### sv/fixed_width_number_to_ascii.sv
// Formats a 32-bit unsigned value as ASCII digits, most significant first, one
// character per clock on result, marked by strobe, with result.last on the
// final one. A transaction is taken when start is high and busy is low. A
// digit_count of 16 or more gives eight upper-case hex digits, starting the
// cycle after the transaction. A count of 1 to 15 gives that many zero-padded
// decimal digits: a bit-serial double-dabble converter shifts in all 32 input
// bits, one per cycle, then the digits follow. A count of 0 gives nothing and
// busy stays low. A new transaction is taken the cycle after the last
// character. The receiver cannot stall: each character is on the ports for
// exactly one cycle and must be taken then.
module fixed_width_number_to_ascii
  import fwna_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  state_t                           state, state_next;
  logic [BIT_CNT_W-1:0]             bit_cnt;
  logic [POS_W-1:0]                 pos;
  logic                             hex_mode;
  logic [VALUE_W-1:0]               hex_word;
  logic                             accept;
  dabble_ctrl_t                     dctrl;
  logic [DEC_DIGITS-1:0][NIB_W-1:0] bcd;
  logic [NIB_W-1:0]                 dec_digit;

  assign accept = start && !busy;

  fwna_dabble u_dabble (
    .clk   (clk),
    .ctrl  (dctrl),
    .value (item.value),
    .bcd   (bcd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.digit_count >= HEX_SELECT) begin
            state_next = ST_EMIT;
          end else if (item.digit_count != '0) begin
            state_next = ST_CONVERT;
          end
        end
      end
      ST_CONVERT: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pos == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (pos < POS_W'(DEC_DIGITS)) begin
      dec_digit = bcd[pos];
    end else begin
      dec_digit = '0;
    end
  end

  always_comb begin
    busy             = 1'b1;
    strobe           = 1'b0;
    dctrl.load       = 1'b0;
    dctrl.step       = 1'b0;
    result.last      = (pos == '0);
    if (hex_mode) begin
      result.character = hex_char(hex_word[VALUE_W-1 -: NIB_W]);
    end else begin
      result.character = ASCII_ZERO + CHAR_W'(dec_digit);
    end
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        dctrl.load = accept;
      end
      ST_CONVERT: begin
        dctrl.step = 1'b1;
      end
      ST_EMIT: begin
        strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      bit_cnt  <= '0;
      pos      <= '0;
      hex_mode <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          bit_cnt <= '0;
          if (accept) begin
            hex_mode <= (item.digit_count >= HEX_SELECT);
            if (item.digit_count >= HEX_SELECT) begin
              pos <= POS_W'(HEX_DIGITS - 1);
            end else begin
              pos <= POS_W'(item.digit_count - COUNT_W'(1));
            end
          end
        end
        ST_CONVERT: begin
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        end
        ST_EMIT: begin
          pos <= pos - POS_W'(1);
        end
        default: begin
          bit_cnt <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hex_word <= item.value;
    end else if (strobe) begin
      hex_word <= {hex_word[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end
  end

  // a number ends with the block ready for the next transaction
  a_last_frees : assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !busy)
    else $error("busy after last character");

  // characters of one number come in consecutive cycles
  a_no_gap : assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a number");

  // hex output starts right after the transaction
  a_hex_start : assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.digit_count >= HEX_SELECT |=> strobe)
    else $error("hex output did not start");

  // a zero count leaves the block idle
  a_zero_idle : assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.digit_count == '0 |=> !busy && !strobe)
    else $error("zero count produced work");

  a_char_range : assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.character >= ASCII_ZERO) && (result.character <= CHAR_W'(70)))
    else $error("character out of range");

endmodule
